/* sv/i2rd_pkg.sv */
// Shared types, constants and the alphabet lookup for the integer to radix digits converter.
`timescale 1ns / 1ps

package i2rd_pkg;

    localparam int DEF_MAX_BASE   = 16;
    localparam int DEF_VALUE_BITS = 32;
    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int BASE_W         = 5;
    localparam int CHARS_W        = 64;
    localparam int ALPHA_LEN      = 16;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0]  RST_BASE_SIZE  = 5'd10;
    localparam logic [CHARS_W-1:0] RST_CHARS_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [CHARS_W-1:0] RST_CHARS_HIGH = 64'h0000_0000_0000_4639;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;

    typedef struct packed {
        logic step;
        logic carry;
    } link_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_LEAD,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [CHARS_W-1:0] chars_low,
        input logic [CHARS_W-1:0] chars_high,
        input logic [3:0]         idx
    );
        logic [2*CHARS_W-1:0] all_chars;
        all_chars = {chars_high, chars_low};
        return all_chars[{idx, 3'b000} +: CHAR_W];
    endfunction

endpackage

/* sv/i2rd_cell.sv */
// One digit cell of the conversion chain: doubles its digit and adds the carry from below.
`timescale 1ns / 1ps

module i2rd_cell
    import i2rd_pkg::*;
#(
    parameter int DW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cell_ctrl_t    ctrl,
    input  logic [DW:0]   base,
    input  link_t         link_in,
    output link_t         link_out,
    input  logic [DW-1:0] digit_in,
    output logic [DW-1:0] digit_out
);

    logic [DW-1:0] digit_reg;
    logic [DW-1:0] digit_next;
    link_t         link_reg;
    link_t         link_next;
    logic [DW:0]   dbl;
    logic          wrap;

    assign dbl  = {digit_reg, link_in.carry};
    assign wrap = (dbl >= base);

    always_comb begin
        digit_next = digit_reg;
        link_next  = '0;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (link_in.step) begin
            digit_next      = wrap ? DW'(dbl - base) : DW'(dbl);
            link_next.step  = 1'b1;
            link_next.carry = wrap;
        end else if (ctrl.shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
        if (!aresetn) begin
            link_reg <= '0;
        end else begin
            link_reg <= link_next;
        end
    end

    assign link_out  = link_reg;
    assign digit_out = digit_reg;

endmodule

/* sv/i2rd_cfg_check.sv */
// Checks the base and the alphabet for a usable configuration.
`timescale 1ns / 1ps

module i2rd_cfg_check
    import i2rd_pkg::*;
#(
    parameter int MAX_BASE = DEF_MAX_BASE
) (
    input  logic [BASE_W-1:0]  base_size,
    input  logic [CHARS_W-1:0] chars_low,
    input  logic [CHARS_W-1:0] chars_high,
    output logic               cfg_ok
);

    logic bad_alpha;

    always_comb begin
        logic [CHAR_W-1:0] ci;
        bad_alpha = 1'b0;
        for (int i = 0; i < ALPHA_LEN; i++) begin
            ci = alpha_char(chars_low, chars_high, 4'(i));
            if (BASE_W'(i) < base_size) begin
                if (ci == CH_MINUS || ci == CH_PLUS) begin
                    bad_alpha = 1'b1;
                end
                for (int j = i + 1; j < ALPHA_LEN; j++) begin
                    if (BASE_W'(j) < base_size &&
                        ci == alpha_char(chars_low, chars_high, 4'(j))) begin
                        bad_alpha = 1'b1;
                    end
                end
            end
        end
    end

    assign cfg_ok = (base_size >= MIN_BASE) && (base_size <= BASE_W'(MAX_BASE)) && !bad_alpha;

endmodule

/* sv/int_to_radix_digits.sv */
// Top level of the converter from a signed integer to its characters in a configured base.
//
//  Channel   Direction  Handshake                Contents
//  s_        in         s_tvalid / s_tready      one integer per word
//  m_        out        m_tvalid / m_tready      one character per word, tlast on the final one
//  cfg_      in         cfg_valid / cfg_ready    register index and write data
//
// A number is taken in, converted in the bit-serial chain, preceded by a minus sign when
// negative, stripped of leading zero positions by shifting the chain and then issued one
// character per digit. Reset is synchronous and restores the configuration registers to
// their reset values and the control to idle. A stalled output holds the character
// read-out; a new word is taken only once the previous number has been fully issued to
// the output register.
`timescale 1ns / 1ps

module int_to_radix_digits
    import i2rd_pkg::*;
#(
    parameter int MAX_BASE   = DEF_MAX_BASE,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [CHAR_W-1:0]      m_tdata,   // [7:0] char_code
    output logic                   m_tlast,   // last_char
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CHARS_W-1:0]     cfg_data
);

    localparam int N         = VALUE_BITS;
    localparam int DW        = $clog2(MAX_BASE);
    localparam int CNT_W     = $clog2(2 * VALUE_BITS);
    localparam int DCNT_W    = $clog2(VALUE_BITS + 1);
    localparam int CONV_LAST = 2 * VALUE_BITS - 2;

    logic [BASE_W-1:0]  base_size_reg;
    logic [CHARS_W-1:0] chars_low_reg;
    logic [CHARS_W-1:0] chars_high_reg;
    logic               cfg_ok;

    state_t             state_reg, state_next;
    logic [N-1:0]       mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [DW:0]        base_reg, base_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    logic [N-1:0]       raw;
    logic               out_free;
    cell_ctrl_t         ctrl;
    link_t              link_first;
    link_t              link [0:N];
    logic [DW-1:0]      digit [0:N-1];
    logic [N-1:0]       step_vec;
    logic [DW-1:0]      top_digit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_size_reg  <= RST_BASE_SIZE;
            chars_low_reg  <= RST_CHARS_LOW;
            chars_high_reg <= RST_CHARS_HIGH;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BASE_SIZE:  base_size_reg  <= cfg_data[BASE_W-1:0];
                CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    i2rd_cfg_check #(
        .MAX_BASE (MAX_BASE)
    ) u_cfg_check (
        .base_size  (base_size_reg),
        .chars_low  (chars_low_reg),
        .chars_high (chars_high_reg),
        .cfg_ok     (cfg_ok)
    );

    assign link[0] = link_first;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            logic [DW-1:0] din;
            if (k == 0) begin : g_bottom
                assign din = '0;
            end else begin : g_upper
                assign din = digit[k-1];
            end
            i2rd_cell #(
                .DW (DW)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .base      (base_reg),
                .link_in   (link[k]),
                .link_out  (link[k+1]),
                .digit_in  (din),
                .digit_out (digit[k])
            );
        end
        for (k = 0; k < N; k++) begin : g_step
            assign step_vec[k] = link[k].step;
        end
    endgenerate

    assign raw       = s_tdata[N-1:0];
    assign top_digit = digit[N-1];
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        base_next        = base_reg;
        cnt_next         = cnt_reg;
        dcnt_next        = dcnt_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        ctrl             = '0;
        link_first.step  = 1'b0;
        link_first.carry = mag_reg[N-1];
        s_tready         = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && cfg_ok) begin
                    neg_next   = raw[N-1];
                    mag_next   = raw[N-1] ? N'(~raw + N'(1)) : raw;
                    base_next  = (DW+1)'(base_size_reg);
                    cnt_next   = '0;
                    ctrl.clear = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (cnt_reg < CNT_W'(VALUE_BITS)) begin
                    link_first.step = 1'b1;
                    mag_next        = {mag_reg[N-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CONV_LAST)) begin
                    dcnt_next  = DCNT_W'(N);
                    state_next = neg_reg ? ST_SIGN : ST_LEAD;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CH_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_LEAD;
                end
            end
            ST_LEAD: begin
                if (top_digit == '0 && dcnt_reg > DCNT_W'(1)) begin
                    ctrl.shift = 1'b1;
                    dcnt_next  = dcnt_reg - DCNT_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = alpha_char(chars_low_reg, chars_high_reg, 4'(top_digit));
                    m_tlast_next  = (dcnt_reg == DCNT_W'(1));
                    ctrl.shift    = 1'b1;
                    dcnt_next     = dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        base_reg    <= base_next;
        dcnt_reg    <= dcnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The magnitude always fits the chain, so the top cell never carries out.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        link[N].step |-> !link[N].carry)
        else $error("digit chain overflowed at the top cell");

    // Once the digits are being read out, no bit may still be travelling up the chain.
    a_chain_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEAD || state_reg == ST_EMIT) |-> (step_vec == '0))
        else $error("read-out started before the chain had settled");

    // Every digit read out lies below the base.
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ({1'b0, top_digit} < base_reg))
        else $error("digit out of range for the base");

endmodule

/* sim/int_to_radix_digits_test.sv */
// Self-checking testbench for the signed integer to radix character converter.
`timescale 1ns / 1ps

module int_to_radix_digits_test;
    import i2rd_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int QUIET_CYCLES = 200;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } char_word_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [CHAR_W-1:0]      m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CHARS_W-1:0]     cfg_data  = '0;

    logic [BASE_W-1:0]  cur_base       = RST_BASE_SIZE;
    logic [CHARS_W-1:0] cur_chars_low  = RST_CHARS_LOW;
    logic [CHARS_W-1:0] cur_chars_high = RST_CHARS_HIGH;

    char_word_t expected_chars[$];
    int         error_count = 0;
    int         idle_cycles = 0;
    bit         send_burst  = 1'b0;
    bit         recv_burst  = 1'b0;

    int_to_radix_digits u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
        if (d < 8) begin
            return cur_chars_low[8*d +: 8];
        end
        return cur_chars_high[8*(d-8) +: 8];
    endfunction

    function automatic bit alphabet_ok();
        logic [CHAR_W-1:0] c;
        if (cur_base < MIN_BASE || cur_base > DEF_MAX_BASE) begin
            return 1'b0;
        end
        for (int i = 0; i < cur_base; i++) begin
            c = digit_char(i);
            if (c == CH_MINUS || c == CH_PLUS) begin
                return 1'b0;
            end
            for (int j = i + 1; j < cur_base; j++) begin
                if (digit_char(j) == c) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_number(input logic [VALUE_W-1:0] v);
        int unsigned mag;
        int unsigned radix;
        int unsigned digs[$];
        char_word_t  w;
        if (!alphabet_ok()) begin
            return;
        end
        radix = cur_base;
        mag = v[VALUE_W-1] ? (~v + 32'd1) : v;
        do begin
            digs.push_front(mag % radix);
            mag = mag / radix;
        end while (mag != 0);
        if (v[VALUE_W-1]) begin
            w.char_code = CH_MINUS;
            w.last_char = 1'b0;
            expected_chars.push_back(w);
        end
        foreach (digs[i]) begin
            w.char_code = digit_char(digs[i]);
            w.last_char = (i == digs.size() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        predict_number(v);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CHARS_W-1:0] data, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (!hold) begin
            cfg_valid <= 1'b0;
        end
        case (idx)
            CFG_BASE_SIZE:  cur_base = data[BASE_W-1:0];
            CFG_CHARS_LOW:  cur_chars_low = data;
            CFG_CHARS_HIGH: cur_chars_high = data;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [BASE_W-1:0] radix,
                                  input logic [CHARS_W-1:0] lo, input logic [CHARS_W-1:0] hi);
        logic [CHARS_W-1:0] base_word;
        wait_results_done();
        repeat (QUIET_CYCLES) @(posedge aclk);
        base_word = {$urandom, $urandom};
        base_word[BASE_W-1:0] = radix;
        write_register(CFG_CHARS_LOW, lo, 1'b1);
        write_register(CFG_CHARS_HIGH, hi, 1'b1);
        write_register(CFG_BASE_SIZE, base_word, 1'b0);
    endtask

    task automatic random_alphabet(output logic [CHARS_W-1:0] lo,
                                   output logic [CHARS_W-1:0] hi);
        bit          used [0:255];
        int unsigned c;
        logic [2*CHARS_W-1:0] all;
        all = '0;
        for (int i = 0; i < 256; i++) begin
            used[i] = 1'b0;
        end
        for (int i = 0; i < ALPHA_LEN; i++) begin
            do c = $urandom_range(0, 255);
            while (used[c] || c == CH_PLUS || c == CH_MINUS);
            used[c] = 1'b1;
            all[8*i +: 8] = CHAR_W'(c);
        end
        lo = all[CHARS_W-1:0];
        hi = all[2*CHARS_W-1:CHARS_W];
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] r;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 80) - 40;
            2: begin
                r = $urandom >> $urandom_range(0, 31);
                return $urandom_range(0, 1) ? -r : r;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    task automatic test_reset_alphabet();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd10);
        send_value(-32'sd123456789);
    endtask

    task automatic test_base_extremes();
        write_settings(5'd2, RST_CHARS_LOW, RST_CHARS_HIGH);
        send_value(32'd0);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'hFFFF_FFFF);
        write_settings(5'd16, RST_CHARS_LOW, 64'h6665_6463_6261_3938);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        write_settings(5'd16, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908);
        send_value(32'd0);
        send_value(32'h1234_ABCD);
    endtask

    task automatic test_rejected_settings();
        write_settings(5'd0, RST_CHARS_LOW, RST_CHARS_HIGH);
        send_value(32'd77);
        write_settings(5'd1, RST_CHARS_LOW, RST_CHARS_HIGH);
        send_value(32'hFFFF_FF00);
        write_settings(5'd17, RST_CHARS_LOW, 64'hFEDC_BA98_7654_3938);
        send_value(32'd5);
        write_settings(5'd31, RST_CHARS_LOW, RST_CHARS_HIGH);
        send_value(32'd6);
        write_settings(5'd10, 64'h3736_3534_3332_312B, RST_CHARS_HIGH);
        send_value(32'd42);
        write_settings(5'd10, RST_CHARS_LOW, 64'h0000_0000_0000_2D38);
        send_value(-32'sd42);
        write_settings(5'd10, RST_CHARS_LOW, 64'h0000_0000_0000_3038);
        send_value(32'd99);
        write_settings(5'd3, 64'h3736_3534_3032_3130, RST_CHARS_HIGH);
        send_value(-32'sd100);
        wait_results_done();
        repeat (QUIET_CYCLES) @(posedge aclk);
        write_register(CFG_SPARE_INDEX, {$urandom, $urandom}, 1'b0);
        send_value(32'd2024);
    endtask

    task automatic test_random_numbers();
        int                 useful;
        int                 phase;
        int                 count;
        bit                 ok;
        logic [BASE_W-1:0]  radix;
        logic [CHARS_W-1:0] lo;
        logic [CHARS_W-1:0] hi;
        useful = 0;
        phase  = 0;
        while (useful < 270) begin
            if ($urandom_range(0, 4) == 0) begin
                radix = BASE_W'($urandom_range(0, 31));
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end else begin
                radix = BASE_W'($urandom_range(2, 16));
                random_alphabet(lo, hi);
            end
            write_settings(radix, lo, hi);
            ok = alphabet_ok();
            count = ok ? 30 : 4;
            for (int k = 0; k < count; k++) begin
                if (phase == 2 && k == 15) begin
                    wait_results_done();
                end
                send_value(random_value());
            end
            if (ok) begin
                useful += count;
            end
            phase++;
        end
    endtask

    initial begin : result_sink
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                recv_burst = !recv_burst;
            end
            gap = recv_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        char_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected word, expected none, got char %h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                w = expected_chars.pop_front();
                if (m_tdata !== w.char_code) begin
                    $display("%0t: char mismatch, expected %h, got %h",
                             $time, w.char_code, m_tdata);
                    error_count++;
                end
                if (m_tlast !== w.last_char) begin
                    $display("%0t: last mismatch, expected %b, got %b",
                             $time, w.last_char, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_alphabet();
        test_base_extremes();
        test_rejected_settings();
        test_random_numbers();
        wait_results_done();
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
